// File: design/krrsp_pkg.sv
// Package for the keyed round-robin slot picker.
// Default sizes, retry limit and result status codes; no dependencies.
`default_nettype none

package krrsp_pkg;

  localparam int unsigned MaxEntries = 5;
  localparam int unsigned NumSlots   = 9;
  localparam int unsigned RetryLimit = 32;
  localparam int unsigned KeyW       = 16;
  localparam int unsigned OutSlotW   = 4;

  typedef enum logic [1:0] {
    StPicked   = 2'd0,
    StFirst    = 2'd1,
    StInserted = 2'd2,
    StFull     = 2'd3
  } status_e;

endpackage

`default_nettype wire

// File: design/krrsp_advance.sv
// Slot advance unit: steps a slot modulo NUM_SLOTS, one step per cycle, until an
// unused slot is found or the retry limit runs out. Depends on krrsp_pkg.
`default_nettype none

module krrsp_advance #(
  parameter int unsigned NUM_SLOTS = krrsp_pkg::NumSlots,
  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [SW-1:0]        slot_i,
  input  wire logic [NUM_SLOTS-1:0] mask_i,
  output logic                      done_o,
  output logic [SW-1:0]             slot_o
);
  import krrsp_pkg::*;

  localparam int unsigned CntW = $clog2(RetryLimit);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [SW-1:0]   s_q, s_d, nxt;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    nxt    = (s_q == SW'(NUM_SLOTS - 1)) ? '0 : s_q + SW'(1);
    busy_d = busy_q;
    done_d = 1'b0;
    s_d    = s_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      s_d    = slot_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      s_d   = nxt;
      cnt_d = cnt_q + CntW'(1);
      if (!mask_i[nxt] || cnt_q == CntW'(RetryLimit - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign slot_o = s_q;

endmodule

`default_nettype wire

// File: design/keyed_round_robin_slot_picker.sv
// Timing: insert or table full scans all n stored entries; first use and slot pick
// end the scan at a hit on entry i; a slot pick then takes k advance steps (1 to 32).
// One request in flight; the next is taken once the result sits in the output
// register, which holds it until taken. The key search and the per-step slot
// advance set the timing. Reset clears the entry count and the handshake state;
// table memories are undefined until an entry is inserted, with no clearing pass.
`default_nettype none

module keyed_round_robin_slot_picker #(
  parameter int unsigned MAX_ENTRIES = krrsp_pkg::MaxEntries,
  parameter int unsigned NUM_SLOTS   = krrsp_pkg::NumSlots
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [krrsp_pkg::KeyW-1:0]      key_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           status_o,
  output logic [krrsp_pkg::OutSlotW-1:0]       slot_o
);
  import krrsp_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_RDST   = 3'd2;
  localparam logic [2:0] S_ADV    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  typedef struct packed {
    logic                 never;
    logic [SW-1:0]        cur;
    logic [NUM_SLOTS-1:0] used;
  } entry_t;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]   hit_idx_q, hit_idx_d;
  logic [KeyW-1:0] key_q, key_d;
  status_e         res_st_q, res_st_d;
  logic [SW-1:0]   res_slot_q, res_slot_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_st_q, out_st_d;
  logic [SW-1:0]   out_slot_q, out_slot_d;

  logic [KeyW-1:0] key_mem [MAX_ENTRIES];
  logic [KeyW-1:0] key_rdata_q;
  logic            key_re, key_we;
  logic [AW-1:0]   key_addr;

  entry_t          st_mem [MAX_ENTRIES];
  entry_t          st_rdata_q;
  entry_t          st_wdata;
  logic            st_re, st_we;
  logic [AW-1:0]   st_addr;

  logic            adv_start, adv_done;
  logic [SW-1:0]   adv_slot;

  krrsp_advance #(.NUM_SLOTS(NUM_SLOTS)) u_adv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (adv_start),
    .slot_i  (st_rdata_q.cur),
    .mask_i  (st_rdata_q.used),
    .done_o  (adv_done),
    .slot_o  (adv_slot)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    hit_idx_d   = hit_idx_q;
    key_d       = key_q;
    res_st_d    = res_st_q;
    res_slot_d  = res_slot_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_slot_d  = out_slot_q;
    key_re      = 1'b0;
    key_we      = 1'b0;
    key_addr    = idx_q[AW-1:0];
    st_re       = 1'b0;
    st_we       = 1'b0;
    st_addr     = cmp_idx_q;
    st_wdata    = '0;
    adv_start   = 1'b0;
    in_ready_o  = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d     = key_i;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          state_d   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (cmp_vld_q && key_rdata_q == key_q) begin
          st_re     = 1'b1;
          st_addr   = cmp_idx_q;
          hit_idx_d = cmp_idx_q;
          cmp_vld_d = 1'b0;
          state_d   = S_RDST;
        end else if (idx_q < count_q) begin
          key_re    = 1'b1;
          key_addr  = idx_q[AW-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end else begin
          cmp_vld_d  = 1'b0;
          res_slot_d = '0;
          state_d    = S_FIN;
          if (count_q < CW'(MAX_ENTRIES)) begin
            key_we         = 1'b1;
            key_addr       = count_q[AW-1:0];
            st_we          = 1'b1;
            st_addr        = count_q[AW-1:0];
            st_wdata.never = 1'b1;
            count_d        = count_q + CW'(1);
            res_st_d       = StInserted;
          end else begin
            res_st_d = StFull;
          end
        end
      end
      S_RDST: begin
        if (st_rdata_q.never) begin
          st_we         = 1'b1;
          st_addr       = hit_idx_q;
          st_wdata.cur  = SW'(1);
          st_wdata.used = NUM_SLOTS'(3);
          res_st_d      = StFirst;
          res_slot_d    = SW'(1);
          state_d       = S_FIN;
        end else begin
          adv_start = 1'b1;
          state_d   = S_ADV;
        end
      end
      S_ADV: begin
        if (adv_done) begin
          st_we         = 1'b1;
          st_addr       = hit_idx_q;
          st_wdata.cur  = adv_slot;
          st_wdata.used = st_rdata_q.used | (NUM_SLOTS'(1) << adv_slot);
          res_st_d      = StPicked;
          res_slot_d    = adv_slot;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_slot_d  = res_slot_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    key_q      <= key_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    out_st_q   <= out_st_d;
    out_slot_q <= out_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_addr] <= key_q;
    if (key_re) key_rdata_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_addr] <= st_wdata;
    if (st_re) st_rdata_q <= st_mem[st_addr];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign slot_o      = OutSlotW'(out_slot_q);

endmodule

`default_nettype wire

// File: design/krrsp_checker.sv
// Port-level checks for the keyed round-robin slot picker, bound to the top level.
// Depends on krrsp_pkg.
`default_nettype none

module krrsp_checker #(
  parameter int unsigned NUM_SLOTS = krrsp_pkg::NumSlots
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [1:0]                     status_o,
  input wire logic [krrsp_pkg::OutSlotW-1:0] slot_o
);
  import krrsp_pkg::*;

  a_no_slot_on_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StInserted || status_o == StFull) |-> slot_o == '0)
    else $error("slot nonzero for insert or table full");

  a_first_use_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StFirst |-> slot_o == OutSlotW'(1))
    else $error("first use did not report slot 1");

  a_picked_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StPicked |-> (NUM_SLOTS > 16) || (slot_o < NUM_SLOTS))
    else $error("picked slot out of range");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_o))
    else $error("result changed while stalled");

endmodule

bind keyed_round_robin_slot_picker krrsp_checker #(.NUM_SLOTS(NUM_SLOTS)) u_krrsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .slot_o      (slot_o)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for the keyed round-robin slot picker: directed table, then random keys.
// Results are checked against typed directed rows or an in-bench model of the key table; needs krrsp_pkg.
`timescale 1ns / 100ps

module testbench;
  import krrsp_pkg::*;

  localparam int unsigned DirRows       = 22;
  localparam int unsigned ItemsPerPhase = 660;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned TailCycles    = 64;
  localparam int unsigned IdleLimit     = 5000;

  typedef struct packed {
    status_e               status;
    logic [OutSlotW-1:0]   slot;
  } pick_t;

  typedef struct {
    logic [KeyW-1:0]       key;
    bit                    typed;
    status_e               status;
    logic [OutSlotW-1:0]   slot;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [KeyW-1:0]      key;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           status;
  logic [OutSlotW-1:0]  slot;

  keyed_round_robin_slot_picker DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .key_i      (key),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .slot_o     (slot)
  );

  // model of the key table
  int unsigned          tbl_count;
  logic [KeyW-1:0]      tbl_key   [MaxEntries];
  logic [NumSlots-1:0]  tbl_used  [MaxEntries];
  int unsigned          tbl_cur   [MaxEntries];
  bit                   tbl_fresh [MaxEntries];

  pick_t        picks_due[$];
  int unsigned  snd_idle;
  int unsigned  rcv_idle;
  bit           hold_req;
  int unsigned  fail_count;
  int unsigned  quiet_cycles;

  dir_row_t dir_tab [DirRows] = '{
    '{16'h0000, 1'b1, StInserted, 4'd0},
    '{16'h0000, 1'b1, StFirst,    4'd1},
    '{16'h0000, 1'b1, StPicked,   4'd2},
    '{16'hFFFF, 1'b1, StInserted, 4'd0},
    '{16'h8001, 1'b1, StInserted, 4'd0},
    '{16'h1234, 1'b1, StInserted, 4'd0},
    '{16'h7FFE, 1'b1, StInserted, 4'd0},
    '{16'h4321, 1'b1, StFull,     4'd0},
    '{16'hFFFE, 1'b1, StFull,     4'd0},
    '{16'hFFFF, 1'b1, StFirst,    4'd1},
    '{16'h0001, 1'b1, StFull,     4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h0000, 1'b0, StPicked,   4'd0},
    '{16'h8001, 1'b1, StFirst,    4'd1},
    '{16'h8001, 1'b0, StPicked,   4'd0},
    '{16'hFFFF, 1'b0, StPicked,   4'd0}
  };

  function automatic pick_t next_pick(input logic [KeyW-1:0] k);
    pick_t        r;
    int           hit;
    int unsigned  s;
    bit           found;
    hit = -1;
    for (int unsigned i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      if (tbl_fresh[hit]) begin
        tbl_fresh[hit] = 1'b0;
        tbl_cur[hit]   = 1;
        tbl_used[hit]  = '0;
        tbl_used[hit][0] = 1'b1;
        tbl_used[hit][1] = 1'b1;
        r.status = StFirst;
        r.slot   = 4'd1;
      end else begin
        s = tbl_cur[hit];
        found = 1'b0;
        for (int unsigned j = 0; j < RetryLimit; j++) begin
          if (!found) begin
            s = (s + 1) % NumSlots;
            if (!tbl_used[hit][s]) found = 1'b1;
          end
        end
        tbl_cur[hit] = s;
        tbl_used[hit][s] = 1'b1;
        r.status = StPicked;
        r.slot   = s[OutSlotW-1:0];
      end
    end else if (tbl_count < MaxEntries) begin
      tbl_key[tbl_count]   = k;
      tbl_fresh[tbl_count] = 1'b1;
      tbl_used[tbl_count]  = '0;
      tbl_cur[tbl_count]   = 0;
      tbl_count++;
      r.status = StInserted;
      r.slot   = '0;
    end else begin
      r.status = StFull;
      r.slot   = '0;
    end
    return r;
  endfunction

  task automatic flag_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // one request; drives on the falling edge and ends on the rising edge where it is taken
  task automatic offer_key(input logic [KeyW-1:0] k, input bit typed, input pick_t typed_res);
    pick_t p;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = next_pick(k);
    picks_due.push_back(typed ? typed_res : p);
  endtask

  task automatic drain_picks();
    @(negedge clk);
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin : check_results
    pick_t want;
    if (rst_n && out_valid && out_ready) begin
      if (picks_due.size() == 0) begin
        flag_fail($sformatf("unexpected result: status %0d slot %0d", status, slot));
      end else begin
        want = picks_due.pop_front();
        if (status !== want.status || slot !== want.slot) begin
          flag_fail($sformatf("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                              want.status, want.slot, status, slot));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("timeout: no request moved for %0d cycles", IdleLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    pick_t typed_res;
    logic [KeyW-1:0] k;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    key        = '0;
    hold_req   = 1'b0;
    fail_count = 0;
    tbl_count  = 0;
    snd_idle   = 29;
    rcv_idle   = 47;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      typed_res.status = dir_tab[r].status;
      typed_res.slot   = dir_tab[r].slot;
      offer_key(dir_tab[r].key, dir_tab[r].typed, typed_res);
    end
    drain_picks();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 29 : (ph == 1) ? 47 : 0;
      rcv_idle = (ph == 0) ? 47 : (ph == 1) ? 29 : 0;
      // long receiver stall while requests keep coming
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(99) < 85) k = tbl_key[$urandom_range(tbl_count - 1)];
        else k = KeyW'($urandom_range(16'hFFFF));
        offer_key(k, 1'b0, typed_res);
      end
      drain_picks();
    end

    repeat (TailCycles) @(posedge clk);
    if (picks_due.size() != 0) flag_fail($sformatf("%0d results never arrived", picks_due.size()));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
